// ===== rtl/ibmt_pkg.sv =====
// ----------------------------------------------------------------------------
// ibmt_pkg
// Shared types, widths and codes of the interval best match tagger.
// ----------------------------------------------------------------------------
package ibmt_pkg;

	localparam int unsigned TABLE_DEPTH_DEFAULT = 1024;

	localparam int unsigned CONTIG_W = 16;
	localparam int unsigned COORD_W  = 31;
	localparam int unsigned ISIZE_W  = 32;
	localparam int unsigned DIST_W   = 32;
	localparam int unsigned MAXD_W   = 16;
	localparam int unsigned ENTRY_W  = 10;
	localparam int unsigned OVL_W    = 11;
	// Signed width that holds the span end, which may run from -1 up to 2^32 - 2.
	localparam int unsigned SPAN_W   = 34;

	localparam logic [MAXD_W-1:0] MAX_DIST_RESET = MAXD_W'(6);

	// Length of the drain state, which lets the last table read reach the best-match update.
	localparam int unsigned DRAIN_CYCLES = 2;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef struct packed {
		logic [CONTIG_W-1:0] contig;
		logic [COORD_W-1:0]  ent_start;
		logic [COORD_W-1:0]  ent_end;
		logic                strand;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic capture;
		logic rd_en;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic scan_done;
	} ctrl_stat_t;

endpackage

// ===== rtl/ibmt_ram.sv =====
// ----------------------------------------------------------------------------
// ibmt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ibmt_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/ibmt_ctrl.sv =====
// ----------------------------------------------------------------------------
// ibmt_ctrl
// Controller: sequences table loads and the per-query table scan.
// ----------------------------------------------------------------------------
module ibmt_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic                   command,
	input  ibmt_pkg::ctrl_stat_t   stat,
	output ibmt_pkg::ctrl_cmd_t    cmd,
	output logic                   busy
);

	import ibmt_pkg::*;

	localparam int unsigned DRAIN_W = (DRAIN_CYCLES > 1) ? $clog2(DRAIN_CYCLES) : 1;

	state_t             state_q, state_d;
	logic [DRAIN_W-1:0] drain_q;
	logic               drain_last;

	assign drain_last = (drain_q == DRAIN_W'(DRAIN_CYCLES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			drain_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DRAIN) begin
				drain_q <= drain_q + DRAIN_W'(1);
			end else begin
				drain_q <= '0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start && command == CMD_QUERY) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (stat.scan_done) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (drain_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy        = 1'b0;
				cmd.load    = start && command == CMD_LOAD;
				cmd.capture = start && command == CMD_QUERY;
			end
			ST_SCAN: begin
				cmd.rd_en = !stat.scan_done;
			end
			ST_DRAIN: begin
			end
			ST_DONE: begin
				cmd.finish = 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== rtl/ibmt_dp.sv =====
// ----------------------------------------------------------------------------
// ibmt_dp
// Datapath: interval table, span setup, scan pipeline and result registers.
// ----------------------------------------------------------------------------
module ibmt_dp #(
	parameter int unsigned TABLE_DEPTH = ibmt_pkg::TABLE_DEPTH_DEFAULT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ibmt_pkg::ctrl_cmd_t            cmd,
	output ibmt_pkg::ctrl_stat_t           stat,
	input  logic                           max_distance_we,
	input  logic [ibmt_pkg::MAXD_W-1:0]    max_distance_wdata,
	input  logic [ibmt_pkg::CONTIG_W-1:0]  contig,
	input  logic [ibmt_pkg::COORD_W-1:0]   entry_start,
	input  logic [ibmt_pkg::COORD_W-1:0]   entry_end,
	input  logic                           entry_strand,
	input  logic [ibmt_pkg::COORD_W-1:0]   read_pos,
	input  logic [ibmt_pkg::COORD_W-1:0]   mate_pos,
	input  logic signed [ibmt_pkg::ISIZE_W-1:0] insert_size,
	input  logic                           is_reverse,
	input  logic                           is_first,
	input  logic                           is_second,
	input  logic                           proper_pair,
	output logic                           done,
	output logic                           tagged_res,
	output logic [ibmt_pkg::ENTRY_W-1:0]   best_entry,
	output logic [ibmt_pkg::DIST_W-1:0]    end_distance,
	output logic [ibmt_pkg::OVL_W-1:0]     overlap_count,
	output logic                           read_strand
);

	import ibmt_pkg::*;

	localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned EW    = $bits(entry_t);

	// Table fill and write port.
	logic [CNT_W-1:0] fill_q;
	logic             table_we;
	entry_t           wr_entry;
	entry_t           rd_entry;

	assign table_we           = cmd.load && (fill_q < CNT_W'(TABLE_DEPTH));
	assign wr_entry.contig    = contig;
	assign wr_entry.ent_start = entry_start;
	assign wr_entry.ent_end   = entry_end;
	assign wr_entry.strand    = entry_strand;

	logic [CNT_W-1:0] scan_q;

	ibmt_ram #(
		.WIDTH (EW),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (table_we),
		.waddr (IDX_W'(fill_q)),
		.wdata (wr_entry),
		.re    (cmd.rd_en),
		.raddr (IDX_W'(scan_q)),
		.rdata (rd_entry)
	);

	// Query setup: span start, span end and source strand.
	logic [ISIZE_W-1:0]       isz_u;
	logic [ISIZE_W-1:0]       isz_mag;
	logic [COORD_W-1:0]       span_start;
	logic [SPAN_W-1:0]        span_end_u;
	logic [CONTIG_W-1:0]      ctg_q;
	logic [COORD_W-1:0]       s_q;
	logic signed [SPAN_W-1:0] e_q;
	logic                     strand_q;
	logic                     proper_q;
	logic [MAXD_W-1:0]        max_dist_q;

	assign isz_u      = insert_size;
	assign isz_mag    = isz_u[ISIZE_W-1] ? (~isz_u + ISIZE_W'(1)) : isz_u;
	assign span_start = is_reverse ? mate_pos : read_pos;
	assign span_end_u = SPAN_W'(span_start) + SPAN_W'(isz_mag) - SPAN_W'(1);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			ctg_q    <= contig;
			s_q      <= span_start;
			e_q      <= $signed(span_end_u);
			strand_q <= (is_first && !is_reverse) || (is_second && is_reverse);
			proper_q <= proper_pair;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			scan_q     <= '0;
			max_dist_q <= MAX_DIST_RESET;
		end else begin
			if (table_we) begin
				fill_q <= fill_q + CNT_W'(1);
			end
			if (cmd.capture) begin
				scan_q <= '0;
			end else if (cmd.rd_en) begin
				scan_q <= scan_q + CNT_W'(1);
			end
			if (max_distance_we) begin
				max_dist_q <= max_distance_wdata;
			end
		end
	end

	assign stat.scan_done = !proper_q || (scan_q >= fill_q);

	// Stage 1 is the registered RAM output; overlap tests and end distances follow.
	logic                     v_s1, v_s2, v_s3;
	logic [IDX_W-1:0]         idx_s1, idx_s2, idx_s3;
	logic signed [SPAN_W-1:0] ts_x, te_x;
	logic signed [SPAN_W-1:0] d2_full;
	logic [COORD_W-1:0]       d1;
	logic                     ovl_s2, ovl_s3;
	logic                     match_s2, match_s3;
	logic [COORD_W-1:0]       d1_s2;
	logic [DIST_W-1:0]        d2_s2;
	logic [DIST_W:0]          dsum;
	logic [DIST_W-1:0]        dist_s3;
	logic                     ovl_hit;

	assign ts_x    = $signed(SPAN_W'(rd_entry.ent_start));
	assign te_x    = $signed(SPAN_W'(rd_entry.ent_end));
	assign ovl_hit = (rd_entry.contig == ctg_q) && (ts_x < e_q) && (rd_entry.ent_end > s_q);
	assign d1      = (rd_entry.ent_start >= s_q) ? (rd_entry.ent_start - s_q)
	                                             : (s_q - rd_entry.ent_start);
	assign d2_full = (te_x >= e_q) ? (te_x - e_q) : (e_q - te_x);
	assign dsum    = (DIST_W + 1)'(d1_s2) + (DIST_W + 1)'(d2_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= cmd.rd_en;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1   <= IDX_W'(scan_q);
		idx_s2   <= idx_s1;
		ovl_s2   <= ovl_hit;
		match_s2 <= ovl_hit && (rd_entry.strand == strand_q);
		d1_s2    <= d1;
		d2_s2    <= d2_full[DIST_W-1:0];
		idx_s3   <= idx_s2;
		ovl_s3   <= ovl_s2;
		match_s3 <= match_s2;
		dist_s3  <= dsum[DIST_W] ? '1 : dsum[DIST_W-1:0];
	end

	// Best-match accumulation; a strict compare keeps the earliest entry on ties.
	logic [CNT_W-1:0]  count_q;
	logic              found_q;
	logic [DIST_W-1:0] best_q;
	logic [IDX_W-1:0]  best_idx_q;
	logic              tag_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			found_q <= 1'b0;
		end else if (cmd.capture) begin
			count_q <= '0;
			found_q <= 1'b0;
		end else if (v_s3) begin
			if (ovl_s3) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (match_s3) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s3 && match_s3 && (!found_q || dist_s3 < best_q)) begin
			best_q     <= dist_s3;
			best_idx_q <= idx_s3;
		end
	end

	assign tag_hit = found_q && (best_q <= DIST_W'(max_dist_q));

	// Result registers, loaded with the done strobe and held until the next result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cmd.finish;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			tagged_res    <= tag_hit;
			best_entry    <= tag_hit ? ENTRY_W'(best_idx_q) : '0;
			end_distance  <= found_q ? best_q : '1;
			overlap_count <= OVL_W'(count_q);
			read_strand   <= strand_q;
		end
	end

endmodule

// ===== rtl/interval_best_match_tagger.sv =====
// ----------------------------------------------------------------------------
// interval_best_match_tagger
// Tags properly paired reads with the closest same-strand overlapping interval.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake                Payload
//   -------   ----------------------   ------------------------------------------
//   item      start / busy             command, contig, entry_*, read_pos, ...
//   result    done (one-cycle strobe)  tagged_res, best_entry, end_distance, ...
//   config    max_distance_we          max_distance_wdata
//
// A load beat writes one entry while the table has room and leaves busy low. A
// query beat scans the N loaded entries through the single table read port, one
// entry per cycle. A read that is not properly paired scans nothing. Done rises
// once the scan has drained, busy falls at the same edge, and the next beat can
// be taken at the edge that ends the strobe. Reset clears the fill count and the
// control state, not the table contents. The result strobe cannot be stalled.
//
module interval_best_match_tagger #(
	parameter int unsigned TABLE_DEPTH = ibmt_pkg::TABLE_DEPTH_DEFAULT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                max_distance_we,
	input  logic [ibmt_pkg::MAXD_W-1:0]         max_distance_wdata,
	input  logic                                command,
	input  logic [ibmt_pkg::CONTIG_W-1:0]       contig,
	input  logic [ibmt_pkg::COORD_W-1:0]        entry_start,
	input  logic [ibmt_pkg::COORD_W-1:0]        entry_end,
	input  logic                                entry_strand,
	input  logic [ibmt_pkg::COORD_W-1:0]        read_pos,
	input  logic [ibmt_pkg::COORD_W-1:0]        mate_pos,
	input  logic signed [ibmt_pkg::ISIZE_W-1:0] insert_size,
	input  logic                                is_reverse,
	input  logic                                is_first,
	input  logic                                is_second,
	input  logic                                proper_pair,
	output logic                                done,
	output logic                                tagged_res,
	output logic [ibmt_pkg::ENTRY_W-1:0]        best_entry,
	output logic [ibmt_pkg::DIST_W-1:0]         end_distance,
	output logic [ibmt_pkg::OVL_W-1:0]          overlap_count,
	output logic                                read_strand
);

	import ibmt_pkg::*;

	ctrl_cmd_t  cmd;
	ctrl_stat_t stat;

	ibmt_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (command),
		.stat    (stat),
		.cmd     (cmd),
		.busy    (busy)
	);

	ibmt_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.stat               (stat),
		.max_distance_we    (max_distance_we),
		.max_distance_wdata (max_distance_wdata),
		.contig             (contig),
		.entry_start        (entry_start),
		.entry_end          (entry_end),
		.entry_strand       (entry_strand),
		.read_pos           (read_pos),
		.mate_pos           (mate_pos),
		.insert_size        (insert_size),
		.is_reverse         (is_reverse),
		.is_first           (is_first),
		.is_second          (is_second),
		.proper_pair        (proper_pair),
		.done               (done),
		.tagged_res         (tagged_res),
		.best_entry         (best_entry),
		.end_distance       (end_distance),
		.overlap_count      (overlap_count),
		.read_strand        (read_strand)
	);

endmodule

// ===== rtl/ibmt_checker.sv =====
// ----------------------------------------------------------------------------
// ibmt_checker
// Port-level checks of the interval best match tagger, bound to the top level.
// ----------------------------------------------------------------------------
module ibmt_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                start,
	input logic                                busy,
	input logic                                command,
	input logic                                done,
	input logic                                tagged_res,
	input logic [ibmt_pkg::ENTRY_W-1:0]        best_entry,
	input logic [ibmt_pkg::DIST_W-1:0]         end_distance
);

	import ibmt_pkg::*;

	// A query beat always starts a scan.
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && command == CMD_QUERY |=> busy)
		else $error("query beat did not raise busy");

	// A load beat never produces a result and leaves the block free.
	a_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && command == CMD_LOAD |=> !busy && !done)
		else $error("load beat produced a result or raised busy");

	// Results are separated by a scan, so two strobes never touch.
	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe lasted more than one cycle");

	// A tagged read lies within a 16-bit limit.
	a_tag_dist: assert property (@(posedge clk) disable iff (!arst_n)
		done && tagged_res |-> end_distance[DIST_W-1:MAXD_W] == '0)
		else $error("tagged result with distance above the register range");

	// An untagged read reports entry zero.
	a_untag_entry: assert property (@(posedge clk) disable iff (!arst_n)
		done && !tagged_res |-> best_entry == '0)
		else $error("untagged result with a nonzero entry index");

endmodule

bind interval_best_match_tagger ibmt_checker u_ibmt_checker (.*);

// ===== dv/interval_best_match_tagger_tb.sv =====
// ----------------------------------------------------------------------------
// interval_best_match_tagger_tb
// Self-checking testbench for the interval best match tagger. A short table of
// directed beats is followed by random table loads and read queries in phases
// that use different distance limits. A small group of entries on a contig of
// its own closes the run. Every query result is compared field by field against
// a directed expectation or a local tagger model with its own interval table copy.
// ----------------------------------------------------------------------------
module interval_best_match_tagger_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ibmt_pkg::*;

	localparam int unsigned TABLE_DEPTH = TABLE_DEPTH_DEFAULT;
	localparam int unsigned PHASES = 6;
	localparam int unsigned PHASE_ITEMS = 90;
	localparam int unsigned FILL_ROWS = 12;
	localparam int unsigned WATCHDOG_LIMIT = 8 * (TABLE_DEPTH + 16);
	localparam longint COORD_MAX = (longint'(1) << COORD_W) - 1;
	localparam logic [CONTIG_W-1:0] FILL_CTG = 16'hC3A5;

	typedef struct packed {
		logic                      command;
		logic [CONTIG_W-1:0]       contig;
		logic [COORD_W-1:0]        entry_start;
		logic [COORD_W-1:0]        entry_end;
		logic                      entry_strand;
		logic [COORD_W-1:0]        read_pos;
		logic [COORD_W-1:0]        mate_pos;
		logic signed [ISIZE_W-1:0] insert_size;
		logic                      is_reverse;
		logic                      is_first;
		logic                      is_second;
		logic                      proper_pair;
	} beat_t;

	typedef struct packed {
		logic               tag_flag;
		logic [ENTRY_W-1:0] best_entry;
		logic [DIST_W-1:0]  end_distance;
		logic [OVL_W-1:0]   overlap_count;
		logic               read_strand;
	} tag_result_t;

	typedef struct packed {
		beat_t       beat;
		logic        typed;
		tag_result_t want;
	} dir_row_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      start = 1'b0;
	logic                      busy;
	logic                      max_distance_we = 1'b0;
	logic [MAXD_W-1:0]         max_distance_wdata = '0;
	logic                      command = CMD_LOAD;
	logic [CONTIG_W-1:0]       contig = '0;
	logic [COORD_W-1:0]        entry_start = '0;
	logic [COORD_W-1:0]        entry_end = '0;
	logic                      entry_strand = 1'b0;
	logic [COORD_W-1:0]        read_pos = '0;
	logic [COORD_W-1:0]        mate_pos = '0;
	logic signed [ISIZE_W-1:0] insert_size = '0;
	logic                      is_reverse = 1'b0;
	logic                      is_first = 1'b0;
	logic                      is_second = 1'b0;
	logic                      proper_pair = 1'b0;
	logic                      done;
	logic                      tagged_res;
	logic [ENTRY_W-1:0]        best_entry;
	logic [DIST_W-1:0]         end_distance;
	logic [OVL_W-1:0]          overlap_count;
	logic                      read_strand;

	// Local copy of the interval table and the distance limit.
	logic [CONTIG_W-1:0] tbl_contig [TABLE_DEPTH];
	logic [COORD_W-1:0]  tbl_start [TABLE_DEPTH];
	logic [COORD_W-1:0]  tbl_end [TABLE_DEPTH];
	logic                tbl_strand [TABLE_DEPTH];
	int unsigned         tbl_count = 0;
	logic [MAXD_W-1:0]   limit_dist = MAX_DIST_RESET;

	tag_result_t pending_tags[$];
	dir_row_t    dir_rows[$];
	int unsigned mismatches = 0;
	int unsigned quiet_cycles = 0;

	interval_best_match_tagger #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.max_distance_we(max_distance_we),
		.max_distance_wdata(max_distance_wdata),
		.command(command),
		.contig(contig),
		.entry_start(entry_start),
		.entry_end(entry_end),
		.entry_strand(entry_strand),
		.read_pos(read_pos),
		.mate_pos(mate_pos),
		.insert_size(insert_size),
		.is_reverse(is_reverse),
		.is_first(is_first),
		.is_second(is_second),
		.proper_pair(proper_pair),
		.done(done),
		.tagged_res(tagged_res),
		.best_entry(best_entry),
		.end_distance(end_distance),
		.overlap_count(overlap_count),
		.read_strand(read_strand)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic tag_result_t predict_tag(input beat_t b);
		longint span_s, span_e, mag, ts, te, sum, best_sum;
		int unsigned hits, best_idx;
		logic found, strand;
		tag_result_t r;
		span_s = b.is_reverse ? longint'(b.mate_pos) : longint'(b.read_pos);
		mag = longint'($signed(b.insert_size));
		if (mag < 0) mag = -mag;
		span_e = span_s + mag - 1;
		strand = (b.is_first && !b.is_reverse) || (b.is_second && b.is_reverse);
		hits = 0;
		best_idx = 0;
		best_sum = 0;
		found = 1'b0;
		if (b.proper_pair) begin
			for (int i = 0; i < tbl_count; i++) begin
				ts = longint'(tbl_start[i]);
				te = longint'(tbl_end[i]);
				if (tbl_contig[i] == b.contig && ts < span_e && te > span_s) begin
					hits++;
					if (tbl_strand[i] == strand) begin
						sum = (ts > span_s ? ts - span_s : span_s - ts)
							+ (te > span_e ? te - span_e : span_e - te);
						if (sum > 64'hFFFF_FFFF) sum = 64'hFFFF_FFFF;
						// Strictly smaller only, so the earliest entry keeps a tie.
						if (!found || sum < best_sum) begin
							found = 1'b1;
							best_sum = sum;
							best_idx = i;
						end
					end
				end
			end
		end
		r.tag_flag = found && best_sum <= longint'(limit_dist);
		r.best_entry = r.tag_flag ? ENTRY_W'(best_idx) : '0;
		r.end_distance = found ? DIST_W'(best_sum) : '1;
		r.overlap_count = OVL_W'(hits);
		r.read_strand = strand;
		return r;
	endfunction

	function automatic logic [COORD_W-1:0] clamp_coord(input longint v);
		if (v < 0) return '0;
		if (v > COORD_MAX) return '1;
		return COORD_W'(v);
	endfunction

	function automatic logic [CONTIG_W-1:0] pick_contig();
		return ($urandom_range(0, 9) == 0) ? CONTIG_W'($urandom) : CONTIG_W'($urandom_range(1, 4));
	endfunction

	function automatic beat_t noise_beat();
		beat_t b;
		b = {$urandom, $urandom, $urandom, $urandom, $urandom, 18'($urandom)};
		return b;
	endfunction

	function automatic beat_t load_beat(input logic [CONTIG_W-1:0] ctg,
			input logic [COORD_W-1:0] st, input logic [COORD_W-1:0] en, input logic strand);
		beat_t b;
		b = '0;
		b.command = CMD_LOAD;
		b.contig = ctg;
		b.entry_start = st;
		b.entry_end = en;
		b.entry_strand = strand;
		return b;
	endfunction

	function automatic beat_t query_beat(input logic [CONTIG_W-1:0] ctg,
			input logic [COORD_W-1:0] rpos, input logic [COORD_W-1:0] mpos,
			input logic [ISIZE_W-1:0] isz, input logic rev, input logic first,
			input logic second, input logic proper);
		beat_t b;
		b = '0;
		b.command = CMD_QUERY;
		b.contig = ctg;
		b.read_pos = rpos;
		b.mate_pos = mpos;
		b.insert_size = isz;
		b.is_reverse = rev;
		b.is_first = first;
		b.is_second = second;
		b.proper_pair = proper;
		return b;
	endfunction

	function automatic dir_row_t plain(input beat_t b);
		dir_row_t r;
		r.beat = b;
		r.typed = 1'b0;
		r.want = '0;
		return r;
	endfunction

	function automatic dir_row_t known(input beat_t b, input logic tg,
			input logic [ENTRY_W-1:0] be, input logic [DIST_W-1:0] d,
			input logic [OVL_W-1:0] cnt, input logic rs);
		dir_row_t r;
		r.beat = b;
		r.typed = 1'b1;
		r.want.tag_flag = tg;
		r.want.best_entry = be;
		r.want.end_distance = d;
		r.want.overlap_count = cnt;
		r.want.read_strand = rs;
		return r;
	endfunction

	function automatic beat_t make_load();
		beat_t b;
		int unsigned j, pick;
		longint st;
		b = noise_beat();
		b.command = CMD_LOAD;
		b.contig = pick_contig();
		pick = $urandom_range(0, 9);
		if (pick < 4 && tbl_count != 0) begin
			// Near or on top of an existing entry, so queries see several overlaps.
			j = $urandom_range(0, tbl_count - 1);
			b.contig = tbl_contig[j];
			if (pick == 0) begin
				b.entry_start = tbl_start[j];
				b.entry_end = tbl_end[j];
				b.entry_strand = tbl_strand[j];
			end else begin
				b.entry_start = clamp_coord(longint'(tbl_start[j])
					+ longint'(int'($urandom_range(0, 40)) - 20));
				b.entry_end = clamp_coord(longint'(tbl_end[j])
					+ longint'(int'($urandom_range(0, 40)) - 20));
			end
		end else if (pick < 9) begin
			st = longint'(b.entry_start);
			if (pick == 8) b.entry_end = clamp_coord(st + longint'($urandom_range(1, 1 << 20)));
			else b.entry_end = clamp_coord(st + longint'($urandom_range(1, 3000)));
		end
		return b;
	endfunction

	function automatic beat_t make_query();
		beat_t b;
		int unsigned j;
		longint s, e, mag;
		logic want_strand;
		b = noise_beat();
		b.command = CMD_QUERY;
		b.contig = pick_contig();
		b.proper_pair = ($urandom_range(0, 9) != 0);
		if (tbl_count != 0 && $urandom_range(0, 4) != 0) begin
			// Build the span around a loaded entry with small end offsets.
			j = $urandom_range(0, tbl_count - 1);
			b.contig = tbl_contig[j];
			s = longint'(clamp_coord(longint'(tbl_start[j])
				+ longint'(int'($urandom_range(0, 30)) - 15)));
			e = longint'(tbl_end[j]) + longint'(int'($urandom_range(0, 30)) - 15);
			mag = e - s + 1;
			if (mag >= 0 && mag <= (longint'(1) << 31)) begin
				b.insert_size = ISIZE_W'($urandom_range(0, 1) ? -mag : mag);
				want_strand = ($urandom_range(0, 4) != 0) ? tbl_strand[j] : 1'($urandom);
				if (b.is_reverse) begin
					b.mate_pos = COORD_W'(s);
					b.is_second = want_strand;
				end else begin
					b.read_pos = COORD_W'(s);
					b.is_first = want_strand;
				end
			end
		end
		return b;
	endfunction

	task automatic issue(input beat_t b, input int unsigned gap, input logic typed,
			input tag_result_t want);
		command <= b.command;
		contig <= b.contig;
		entry_start <= b.entry_start;
		entry_end <= b.entry_end;
		entry_strand <= b.entry_strand;
		read_pos <= b.read_pos;
		mate_pos <= b.mate_pos;
		insert_size <= b.insert_size;
		is_reverse <= b.is_reverse;
		is_first <= b.is_first;
		is_second <= b.is_second;
		proper_pair <= b.proper_pair;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		if (b.command == CMD_QUERY) begin
			pending_tags.push_back(typed ? want : predict_tag(b));
		end else if (tbl_count < TABLE_DEPTH) begin
			tbl_contig[tbl_count] = b.contig;
			tbl_start[tbl_count] = b.entry_start;
			tbl_end[tbl_count] = b.entry_end;
			tbl_strand[tbl_count] = b.entry_strand;
			tbl_count++;
		end
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Only called with start low; waits for the block to go quiet first.
	task automatic set_limit(input logic [MAXD_W-1:0] v);
		while (pending_tags.size() != 0 || busy) @(posedge clk);
		repeat (DRAIN_CYCLES + 6) @(posedge clk);
		max_distance_wdata <= v;
		max_distance_we <= 1'b1;
		@(posedge clk);
		max_distance_we <= 1'b0;
		limit_dist = v;
	endtask

	always @(posedge clk) begin : check_tags
		tag_result_t want;
		if (arst_n && done) begin
			if (pending_tags.size() == 0) begin
				$display("%0t: result beat with nothing expected", $time);
				mismatches++;
			end else begin
				want = pending_tags.pop_front();
				if (tagged_res !== want.tag_flag) begin
					$display("%0t: tagged_res expected %0b got %0b", $time, want.tag_flag,
						tagged_res);
					mismatches++;
				end
				if (best_entry !== want.best_entry) begin
					$display("%0t: best_entry expected %0d got %0d", $time,
						want.best_entry, best_entry);
					mismatches++;
				end
				if (end_distance !== want.end_distance) begin
					$display("%0t: end_distance expected %h got %h", $time,
						want.end_distance, end_distance);
					mismatches++;
				end
				if (overlap_count !== want.overlap_count) begin
					$display("%0t: overlap_count expected %0d got %0d", $time,
						want.overlap_count, overlap_count);
					mismatches++;
				end
				if (read_strand !== want.read_strand) begin
					$display("%0t: read_strand expected %0b got %0b", $time,
						want.read_strand, read_strand);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		beat_t b;
		logic burst;
		logic [MAXD_W-1:0] phase_limits [PHASES];
		logic [MAXD_W-1:0] tail_limits [2];

		// Empty table, flag decoding, edge of the half-open test, limit boundary,
		// extreme coordinates and insert sizes, ties and inverted entries.
		dir_rows.push_back(known(query_beat(16'd5, 31'd100, 31'd0, 32'sd101, 1'b0, 1'b1, 1'b0,
			1'b1), 1'b0, '0, '1, '0, 1'b1));
		dir_rows.push_back(known(query_beat(16'd5, 31'h7FFF_FFFF, 31'h7FFF_FFFF, -32'sd1, 1'b1,
			1'b0, 1'b1, 1'b0), 1'b0, '0, '1, '0, 1'b1));
		dir_rows.push_back(known(query_beat(16'hFFFF, 31'd0, 31'd0, 32'h8000_0000, 1'b0, 1'b0,
			1'b0, 1'b0), 1'b0, '0, '1, '0, 1'b0));
		dir_rows.push_back(plain(load_beat(16'd5, 31'd100, 31'd200, 1'b1)));
		dir_rows.push_back(plain(load_beat(16'd5, 31'd100, 31'd200, 1'b1)));
		dir_rows.push_back(plain(load_beat(16'd5, 31'd90, 31'd210, 1'b0)));
		dir_rows.push_back(plain(load_beat(16'd6, 31'd100, 31'd200, 1'b1)));
		dir_rows.push_back(plain(load_beat(16'hFFFF, 31'd0, 31'h7FFF_FFFF, 1'b1)));
		dir_rows.push_back(plain(load_beat(16'd5, 31'h7FFF_FFFF, 31'd0, 1'b0)));
		dir_rows.push_back(known(query_beat(16'd5, 31'd100, 31'd0, 32'sd101, 1'b0, 1'b1, 1'b0,
			1'b1), 1'b1, '0, '0, 11'd3, 1'b1));
		dir_rows.push_back(plain(query_beat(16'd5, 31'd150, 31'd0, 32'sd0, 1'b0, 1'b1, 1'b0,
			1'b1)));
		dir_rows.push_back(plain(query_beat(16'd5, 31'd500, 31'd95, -32'sd110, 1'b1, 1'b0, 1'b1,
			1'b1)));
		dir_rows.push_back(plain(query_beat(16'd5, 31'd0, 31'd90, 32'sd121, 1'b1, 1'b1, 1'b0,
			1'b1)));
		dir_rows.push_back(known(query_beat(16'hFFFF, 31'd0, 31'h7FFF_FFFF, 32'h8000_0000, 1'b0,
			1'b1, 1'b0, 1'b1), 1'b1, 10'd4, '0, 11'd1, 1'b1));
		dir_rows.push_back(plain(query_beat(16'hFFFF, 31'h7FFF_FFFE, 31'd0, 32'h7FFF_FFFF, 1'b0,
			1'b1, 1'b0, 1'b1)));
		dir_rows.push_back(known(query_beat(16'd6, 31'd100, 31'd0, 32'sd101, 1'b0, 1'b0, 1'b1,
			1'b1), 1'b0, '0, '1, 11'd1, 1'b0));
		dir_rows.push_back(plain(query_beat(16'd5, 31'd0, 31'd100, -32'sd101, 1'b1, 1'b1, 1'b1,
			1'b1)));
		dir_rows.push_back(plain(query_beat(16'd5, 31'd200, 31'd0, 32'sd50, 1'b0, 1'b1, 1'b0,
			1'b1)));
		dir_rows.push_back(plain(query_beat(16'd5, 31'd0, 31'd0, 32'sd91, 1'b0, 1'b1, 1'b0,
			1'b1)));
		dir_rows.push_back(plain(query_beat(16'd5, 31'd97, 31'd0, 32'sd107, 1'b0, 1'b1, 1'b0,
			1'b1)));
		dir_rows.push_back(plain(query_beat(16'd5, 31'd97, 31'd0, 32'sd108, 1'b0, 1'b1, 1'b0,
			1'b1)));

		phase_limits = '{16'hFFFF, 16'd0, 16'($urandom), 16'd3, 16'd20, 16'd12};
		tail_limits = '{16'hFFFF, 16'd0};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[k])
			issue(dir_rows[k].beat, $urandom_range(0, 6), dir_rows[k].typed, dir_rows[k].want);
		start <= 1'b0;

		burst = 1'b0;
		for (int ph = 0; ph < PHASES; ph++) begin
			set_limit(phase_limits[ph]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 40 == 0) burst = ($urandom_range(0, 3) == 0);
				b = ($urandom_range(0, 99) < 35) ? make_load() : make_query();
				issue(b, burst ? 0 : $urandom_range(0, 6), 1'b0, '0);
			end
			start <= 1'b0;
		end

		// A group on the fill contig; the last entry is its only exact match.
		for (int f = 0; f < FILL_ROWS; f++) begin
			if (f == FILL_ROWS - 1) b = load_beat(FILL_CTG, 31'd5000, 31'd9000, 1'b1);
			else b = load_beat(FILL_CTG, COORD_W'(5000 + f % 50),
				COORD_W'(9000 - f % 37), f % 3 != 0);
			issue(b, $urandom_range(0, 2), 1'b0, '0);
		end
		start <= 1'b0;

		foreach (tail_limits[t]) begin
			set_limit(tail_limits[t]);
			issue(query_beat(FILL_CTG, 31'd5000, 31'd77, 32'sd4001, 1'b0, 1'b1, 1'b0, 1'b1),
				$urandom_range(0, 6), 1'b0, '0);
			issue(query_beat(FILL_CTG, 31'd12345, 31'd5000, -32'sd4001, 1'b1, 1'b0, 1'b1, 1'b1),
				$urandom_range(0, 6), 1'b0, '0);
			issue(query_beat(FILL_CTG + CONTIG_W'(1), 31'd5000, 31'd0, 32'sd4001, 1'b0, 1'b1,
				1'b0, 1'b1), $urandom_range(0, 6), 1'b0, '0);
			repeat (3) issue(make_query(), $urandom_range(0, 6), 1'b0, '0);
			start <= 1'b0;
		end

		while (pending_tags.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES + 8) @(posedge clk);
		if (mismatches == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end

endmodule

// ===== interval_best_match_tagger.f =====
rtl/ibmt_pkg.sv
rtl/ibmt_ram.sv
rtl/ibmt_ctrl.sv
rtl/ibmt_dp.sv
rtl/interval_best_match_tagger.sv
rtl/ibmt_checker.sv
dv/interval_best_match_tagger_tb.sv
